[sv/point_cutoff_dedup_nearest_remap_macros.svh]
// Assertion macros shared by the checker of the point filter.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef POINT_CUTOFF_DEDUP_NEAREST_REMAP_MACROS_SVH
`define POINT_CUTOFF_DEDUP_NEAREST_REMAP_MACROS_SVH

// Same-cycle implication.
`define PCDN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PCDN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pcdn_pkg.sv]
// Types, sizes and codes for the point cutoff filter.
// Used by the top level, the RAM wrapper users and the checker.
package pcdn_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 24;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CUT_W      = 52;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS + 1;
   localparam int DIST_W     = SQ_W + 2;
   localparam int CMP_W      = (DIST_W > CUT_W) ? DIST_W : CUT_W;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] CSR_CUTOFF = 2'd0;
   localparam logic [1:0] CSR_FILTER = 2'd1;
   localparam logic [1:0] CSR_DIMS   = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [IDX_W-1:0] point_index;
      coord_type        coord_x;
      coord_type        coord_y;
      coord_type        coord_z;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             kept_flag;
      logic [IDX_W-1:0] mapped_index;
      logic [CNT_W-1:0] kept_total;
      coord_type        out_x;
      coord_type        out_y;
      coord_type        out_z;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } kp_entry_type;

   typedef struct packed {
      coord_type        x;
      coord_type        y;
      coord_type        z;
      logic             kept;
      logic [IDX_W-1:0] compact;
   } pt_entry_type;

endpackage

[sv/pcdn_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pcdn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/point_cutoff_dedup_nearest_remap.sv]
// Clear, store-full and out-of-range requests and adds without a scan go straight to the
// result state; reads and queries first look up their RAM entry, and reads and kept-point
// queries then finish. A filtered add and an excluded-point query scan the kept-point RAM,
// one kept point read per cycle through a 2-stage distance pipeline. One request is in work
// at a time; a new one is taken while a result waits. Reset (synchronous, active high) zeroes
// the counts, loads the register defaults and clears the state and the valid flags only.
module point_cutoff_dedup_nearest_remap (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pcdn_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pcdn_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [pcdn_pkg::CUT_W-1:0]   csr_wdata
);
   import pcdn_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CUT_W-1:0] cutoff_ff;
   logic             filt_ff;
   logic [1:0]       dims_ff;
   logic [CNT_W-1:0] pcount_ff, pcount_in, kcount_ff, kcount_in;
   logic [1:0]       act_ff, act_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   kp_entry_type     cur_ff, cur_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             v1_ff, v2_ff;
   logic [IDX_W-1:0] idx1_ff, idx2_ff;
   logic [SQ_W-1:0]  sqx_ff, sqy_ff, sqz_ff;
   logic             found_ff, found_in, have_ff, have_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] bidx_ff, bidx_in;
   rsp_type          res_ff, res_in, rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             pt_we, kp_we;
   logic [IDX_W-1:0] pt_waddr, kp_waddr, pt_raddr, kp_raddr;
   pt_entry_type     pt_wdata, pt_rdata;
   kp_entry_type     kp_wdata, kp_rdata;

   logic             issue, scan_done, finish_add, add_excl;
   kp_entry_type     add_pt;
   logic [DIST_W-1:0] dist_sum;
   logic signed [DIFF_W-1:0]   dx, dy, dz;
   logic signed [2*DIFF_W-1:0] px, py, pz;

   pcdn_ram #(.WIDTH($bits(pt_entry_type)), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clock(clock), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
      .raddr(pt_raddr), .rdata(pt_rdata)
   );

   pcdn_ram #(.WIDTH($bits(kp_entry_type)), .DEPTH(MAX_POINTS)) u_kp_ram (
      .clock(clock), .we(kp_we), .waddr(kp_waddr), .wdata(kp_wdata),
      .raddr(kp_raddr), .rdata(kp_rdata)
   );

   // Distance stage one: coordinate differences, masked by dims, and their squares.
   always_comb begin
      dx = (dims_ff != 2'd0) ? ({kp_rdata.x[COORD_BITS-1], kp_rdata.x}
           - {cur_ff.x[COORD_BITS-1], cur_ff.x}) : '0;
      dy = (dims_ff >= 2'd2) ? ({kp_rdata.y[COORD_BITS-1], kp_rdata.y}
           - {cur_ff.y[COORD_BITS-1], cur_ff.y}) : '0;
      dz = (dims_ff == 2'd3) ? ({kp_rdata.z[COORD_BITS-1], kp_rdata.z}
           - {cur_ff.z[COORD_BITS-1], cur_ff.z}) : '0;
      px = dx * dx;
      py = dy * dy;
      pz = dz * dz;
   end

   // Distance stage two: sum of the registered squares.
   assign dist_sum = DIST_W'(sqx_ff) + DIST_W'(sqy_ff) + DIST_W'(sqz_ff);

   assign issue     = (state_ff == S_SCAN) && (iss_ff != kcount_ff);
   assign scan_done = (state_ff == S_SCAN) && !issue && !v1_ff && !v2_ff;

   always_comb begin
      state_in     = state_ff;
      pcount_in    = pcount_ff;
      kcount_in    = kcount_ff;
      act_in       = act_ff;
      pidx_in      = pidx_ff;
      cur_in       = cur_ff;
      iss_in       = iss_ff;
      found_in     = found_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      bidx_in      = bidx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pt_raddr     = req_data.point_index;
      kp_raddr     = iss_ff[IDX_W-1:0];
      finish_add   = 1'b0;
      add_excl     = 1'b0;
      add_pt       = cur_ff;

      if (issue) begin
         iss_in = iss_ff + CNT_W'(1);
      end

      // Running match: first hit for an add, strict minimum for a query.
      if (v2_ff) begin
         if (act_ff == ACT_ADD) begin
            if (!found_ff && (CMP_W'(dist_sum) <= CMP_W'(cutoff_ff))) begin
               found_in = 1'b1;
               bidx_in  = idx2_ff;
            end
         end else if (!have_ff || dist_sum < best_ff) begin
            have_in = 1'b1;
            best_in = dist_sum;
            bidx_in = idx2_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in  = req_data.action;
               pidx_in = req_data.point_index;
               cur_in  = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};
               res_in  = '0;
               res_in.kept_total = kcount_ff;
               kp_raddr = req_data.point_index;
               state_in = S_FIN;
               case (req_data.action)
                  ACT_ADD: begin
                     if (pcount_ff == CNT_W'(MAX_POINTS)) begin
                        res_in.status = ST_FULL;
                     end else if (filt_ff && kcount_ff != '0) begin
                        state_in = S_SCAN;
                        iss_in   = '0;
                        found_in = 1'b0;
                     end else begin
                        finish_add = 1'b1;
                        add_pt = '{x: req_data.coord_x, y: req_data.coord_y,
                                   z: req_data.coord_z};
                     end
                  end
                  ACT_QUERY: begin
                     if ({1'b0, req_data.point_index} >= pcount_ff) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  ACT_READ: begin
                     if ({1'b0, req_data.point_index} >= kcount_ff) begin
                        res_in.status = ST_RANGE;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  default: begin
                     pcount_in = '0;
                     kcount_in = '0;
                     res_in.kept_total = '0;
                  end
               endcase
            end
         end
         S_LOOK: begin
            if (act_ff == ACT_READ) begin
               res_in.kept_flag    = 1'b1;
               res_in.mapped_index = pidx_ff;
               res_in.out_x        = kp_rdata.x;
               res_in.out_y        = kp_rdata.y;
               res_in.out_z        = kp_rdata.z;
               state_in = S_FIN;
            end else if (pt_rdata.kept) begin
               res_in.kept_flag    = 1'b1;
               res_in.mapped_index = pt_rdata.compact;
               state_in = S_FIN;
            end else begin
               cur_in   = '{x: pt_rdata.x, y: pt_rdata.y, z: pt_rdata.z};
               iss_in   = '0;
               have_in  = 1'b0;
               bidx_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (act_ff == ACT_ADD) begin
                  finish_add = 1'b1;
                  add_excl   = found_ff;
               end else begin
                  res_in.mapped_index = bidx_ff;
                  state_in = S_FIN;
               end
            end
         end
         default: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase

      pt_we    = finish_add;
      pt_waddr = pcount_ff[IDX_W-1:0];
      pt_wdata = '{x: add_pt.x, y: add_pt.y, z: add_pt.z, kept: !add_excl,
                   compact: add_excl ? bidx_ff : kcount_ff[IDX_W-1:0]};
      kp_we    = finish_add && !add_excl;
      kp_waddr = kcount_ff[IDX_W-1:0];
      kp_wdata = add_pt;
      if (finish_add) begin
         pcount_in = pcount_ff + CNT_W'(1);
         if (!add_excl) begin
            kcount_in = kcount_ff + CNT_W'(1);
         end
         res_in.status       = ST_OK;
         res_in.kept_flag    = !add_excl;
         res_in.mapped_index = pt_wdata.compact;
         res_in.kept_total   = add_excl ? kcount_ff : kcount_ff + CNT_W'(1);
         state_in = S_FIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cutoff_ff    <= '0;
         filt_ff      <= 1'b1;
         dims_ff      <= 2'd3;
         pcount_ff    <= '0;
         kcount_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         kcount_ff    <= kcount_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CUTOFF: cutoff_ff <= csr_wdata;
               CSR_FILTER: filt_ff   <= csr_wdata[0];
               CSR_DIMS:   dims_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      pidx_ff  <= pidx_in;
      cur_ff   <= cur_in;
      iss_ff   <= iss_in;
      found_ff <= found_in;
      have_ff  <= have_in;
      best_ff  <= best_in;
      bidx_ff  <= bidx_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      idx1_ff  <= iss_ff[IDX_W-1:0];
      idx2_ff  <= idx1_ff;
      sqx_ff   <= px[SQ_W-1:0];
      sqy_ff   <= py[SQ_W-1:0];
      sqz_ff   <= pz[SQ_W-1:0];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/pcdn_checker.sv]
// Port-level checks for the point filter, bound to the top level.
// Depends on pcdn_pkg and the assertion macro header.
`include "point_cutoff_dedup_nearest_remap_macros.svh"

module pcdn_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input pcdn_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pcdn_pkg::rsp_type rsp_data
);
   import pcdn_pkg::*;

   `PCDN_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_data), "request dropped or changed while waiting")
   `PCDN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
   `PCDN_ASSERT_NOW(a_status_code, rsp_valid, rsp_data.status <= ST_RANGE, "undefined status code")
   `PCDN_ASSERT_NOW(a_err_fields, rsp_valid && rsp_data.status != ST_OK, !rsp_data.kept_flag && rsp_data.mapped_index == '0, "error response carries a mapping")
   `PCDN_ASSERT_NOW(a_total_bound, rsp_valid, rsp_data.kept_total <= CNT_W'(MAX_POINTS), "kept total above capacity")

endmodule

bind point_cutoff_dedup_nearest_remap pcdn_checker u_pcdn_checker (.*);

[bench/point_cutoff_dedup_nearest_remap_test.sv]
// Testbench for the greedy point cutoff filter with nearest-kept remapping.
// Depends on pcdn_pkg and the point_cutoff_dedup_nearest_remap top level.
`timescale 1ns / 1ps

module point_cutoff_dedup_nearest_remap_test;
   import pcdn_pkg::*;

   class remap_scoreboard;
      logic [CUT_W-1:0] cutoff_sq;
      bit               filter_on;
      logic [1:0]       dim_count;
      coord_type        px[MAX_POINTS];
      coord_type        py[MAX_POINTS];
      coord_type        pz[MAX_POINTS];
      bit               pkept[MAX_POINTS];
      int               pcompact[MAX_POINTS];
      int               korigin[MAX_POINTS];
      int               point_count;
      int               kept_count;
      rsp_type          pending[$];
      int               mismatches;
      int               checked;
      int               excluded_seen;
      int               nearest_seen;

      function new();
         cutoff_sq = '0;
         filter_on = 1'b1;
         dim_count = 2'd3;
         point_count = 0;
         kept_count = 0;
         mismatches = 0;
         checked = 0;
         excluded_seen = 0;
         nearest_seen = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [CUT_W-1:0] value);
         case (index)
            CSR_CUTOFF: cutoff_sq = value;
            CSR_FILTER: filter_on = value[0];
            CSR_DIMS:   dim_count = value[1:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] sq_dist(int p, coord_type x, coord_type y, coord_type z);
         logic signed [63:0] d;
         logic [63:0] s;
         s = 0;
         if (dim_count >= 1) begin
            d = 64'(px[p]) - 64'(x);
            s += d * d;
         end
         if (dim_count >= 2) begin
            d = 64'(py[p]) - 64'(y);
            s += d * d;
         end
         if (dim_count >= 3) begin
            d = 64'(pz[p]) - 64'(z);
            s += d * d;
         end
         return s;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int p;
         int besti;
         logic [63:0] best;
         logic [63:0] d;
         bit excl;
         e = '0;
         case (r.action)
            ACT_ADD: begin
               if (point_count >= MAX_POINTS) begin
                  e.status = ST_FULL;
               end else begin
                  p = point_count;
                  px[p] = r.coord_x;
                  py[p] = r.coord_y;
                  pz[p] = r.coord_z;
                  excl = 0;
                  if (filter_on) begin
                     for (int k = 0; k < kept_count && !excl; k++) begin
                        if (sq_dist(korigin[k], r.coord_x, r.coord_y, r.coord_z)
                            <= 64'(cutoff_sq)) begin
                           excl = 1;
                           pcompact[p] = k;
                        end
                     end
                  end
                  if (excl) begin
                     pkept[p] = 0;
                     excluded_seen++;
                  end else begin
                     pkept[p] = 1;
                     pcompact[p] = kept_count;
                     korigin[kept_count] = p;
                     kept_count++;
                     e.kept_flag = 1;
                  end
                  e.mapped_index = pcompact[p][IDX_W-1:0];
                  point_count++;
               end
            end
            ACT_QUERY: begin
               if (r.point_index >= point_count) begin
                  e.status = ST_RANGE;
               end else if (pkept[r.point_index]) begin
                  e.kept_flag = 1;
                  e.mapped_index = pcompact[r.point_index][IDX_W-1:0];
               end else begin
                  best = 0;
                  besti = 0;
                  for (int k = 0; k < kept_count; k++) begin
                     d = sq_dist(korigin[k], px[r.point_index], py[r.point_index],
                                 pz[r.point_index]);
                     if (k == 0 || d < best) begin
                        best = d;
                        besti = k;
                     end
                  end
                  e.mapped_index = besti[IDX_W-1:0];
                  nearest_seen++;
               end
            end
            ACT_READ: begin
               if (r.point_index >= kept_count) begin
                  e.status = ST_RANGE;
               end else begin
                  p = korigin[r.point_index];
                  e.kept_flag = 1;
                  e.mapped_index = r.point_index;
                  e.out_x = px[p];
                  e.out_y = py[p];
                  e.out_z = pz[p];
               end
            end
            default: begin
               point_count = 0;
               kept_count = 0;
            end
         endcase
         e.kept_total = kept_count[CNT_W-1:0];
         pending = {pending, e};
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status || got.kept_flag !== e.kept_flag ||
             got.mapped_index !== e.mapped_index || got.kept_total !== e.kept_total ||
             got.out_x !== e.out_x || got.out_y !== e.out_y || got.out_z !== e.out_z) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [CUT_W-1:0]  csr_wdata;

   remap_scoreboard   board;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                quiet_cycles;
   int                request_total;
   bit                timed_out;

   localparam int WATCHDOG_LIMIT = 40000;

   point_cutoff_dedup_nearest_remap i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random; results are checked at the accepting edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("point_cutoff_dedup_nearest_remap verification failed");
            $finish;
         end
      end
   end

   // Valid stays high between back-to-back requests and drops only while the sender idles.
   task automatic send_request(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
      request_total++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      // Allow the block to settle fully before anything else.
      repeat (MAX_POINTS + 20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [CUT_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_req(logic [1:0] action, int idx,
                                        coord_type x, coord_type y, coord_type z);
      req_type r;
      r.action = action;
      r.point_index = idx[IDX_W-1:0];
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      return r;
   endfunction

   function automatic coord_type near_coord(int spread);
      // Points cluster near a small set of centers so that the cutoff bites.
      return coord_type'($urandom_range(3) * 100 - 150 + $signed($urandom_range(2 * spread))
                         - spread);
   endfunction

   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   task automatic random_phase(int count, int spread);
      req_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            if (pick < 45)
               r = make_req(ACT_ADD, $urandom, near_coord(spread), near_coord(spread),
                            near_coord(spread));
            else
               r = make_req(ACT_ADD, $urandom, any_coord(), any_coord(), any_coord());
         end else if (pick < 78) begin
            r = make_req(ACT_QUERY, (pick < 75) ? $urandom_range(board.point_count) :
                         $urandom_range(1023), any_coord(), any_coord(), any_coord());
         end else if (pick < 97) begin
            r = make_req(ACT_READ, (pick < 94) ? $urandom_range(board.kept_count) :
                         $urandom_range(1023), any_coord(), any_coord(), any_coord());
         end else begin
            r = make_req(ACT_CLEAR, $urandom, any_coord(), any_coord(), any_coord());
         end
         send_request(r);
      end
   endtask

   localparam coord_type CMAX = 24'sh7FFFFF;
   localparam coord_type CMIN = -24'sh800000;

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_CUTOFF;
      csr_wdata = '0;
      rsp_ready = 1'b0;
      quiet_cycles = 0;
      request_total = 0;
      timed_out = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: range errors on an empty store, extremes, exclusion and remap.
      send_request(make_req(ACT_QUERY, 0, 0, 0, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0));
      send_request(make_req(ACT_ADD, 1023, CMAX, CMAX, CMAX));
      send_request(make_req(ACT_ADD, 0, CMIN, CMIN, CMIN));
      send_request(make_req(ACT_ADD, 5, CMAX, CMAX, CMAX));
      send_request(make_req(ACT_QUERY, 2, 0, 0, 0));
      send_request(make_req(ACT_QUERY, 1, 0, 0, 0));
      send_request(make_req(ACT_READ, 1, 0, 0, 0));
      send_request(make_req(ACT_READ, 1023, 0, 0, 0));
      send_request(make_req(ACT_QUERY, 1023, 0, 0, 0));
      drain();
      write_reg(CSR_CUTOFF, {CUT_W{1'b1}});
      write_reg(CSR_DIMS, 2'd1);
      send_request(make_req(ACT_ADD, 0, 24'sd5, CMIN, CMAX));
      send_request(make_req(ACT_QUERY, 3, 0, 0, 0));
      send_request(make_req(ACT_CLEAR, 0, 0, 0, 0));
      send_request(make_req(ACT_ADD, 0, 24'sd10, 24'sd0, 24'sd0));
      send_request(make_req(ACT_ADD, 0, 24'sd20, 24'sd0, 24'sd0));
      drain();
      write_reg(CSR_DIMS, 2'd0);
      write_reg(CSR_FILTER, 1'b0);
      send_request(make_req(ACT_ADD, 0, 24'sd30, 24'sd1, 24'sd1));
      send_request(make_req(ACT_ADD, 0, 24'sd30, 24'sd1, 24'sd1));
      drain();
      write_reg(CSR_FILTER, 1'b1);
      write_reg(CSR_CUTOFF, 52'd0);
      write_reg(CSR_DIMS, 2'd3);
      // Zero cutoff still excludes an exact duplicate; query picks the nearest.
      send_request(make_req(ACT_CLEAR, 0, 0, 0, 0));
      send_request(make_req(ACT_ADD, 0, 24'sd7, -24'sd7, 24'sd7));
      send_request(make_req(ACT_ADD, 0, 24'sd7, -24'sd7, 24'sd7));
      send_request(make_req(ACT_QUERY, 1, 0, 0, 0));

      // Random phases with changing settings and idle mixes.
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(CSR_CUTOFF, 52'd2500);
               send_idle_pct = 32; recv_idle_pct = 64;
            end
            1: begin
               write_reg(CSR_DIMS, 2'd2);
               write_reg(CSR_CUTOFF, 52'd20000);
            end
            2: begin
               write_reg(CSR_DIMS, 2'd1);
               send_idle_pct = 64; recv_idle_pct = 32;
            end
            3: begin
               write_reg(CSR_DIMS, 2'd3);
               write_reg(CSR_CUTOFF, {CUT_W{1'b1}} >> 20);
            end
            4: begin
               write_reg(CSR_FILTER, 1'b0);
               send_idle_pct = 0; recv_idle_pct = 0;
            end
            default: begin
               write_reg(CSR_FILTER, 1'b1);
               write_reg(CSR_CUTOFF, 52'd900);
            end
         endcase
         random_phase(93, (ph == 3) ? 4000 : 60);
      end

      send_request(make_req(ACT_READ, 1023, 0, 0, 0));
      send_request(make_req(ACT_QUERY, 1023, 0, 0, 0));
      send_request(make_req(ACT_CLEAR, 0, 0, 0, 0));

      drain();
      $display("Ran %0d requests (%0d results checked) over several cutoff, filter and",
               request_total, board.checked);
      $display("dims settings; %0d adds excluded, %0d nearest-point remaps.",
               board.excluded_seen, board.nearest_seen);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("point_cutoff_dedup_nearest_remap verification clean");
      end else begin
         $display("point_cutoff_dedup_nearest_remap verification failed");
      end
      $finish;
   end

endmodule
